### sv/l16ada_pkg.sv
// Package for the 4-bit PQ table distance accumulator.
// Holds widths, register indexes, item kinds and result-mode codes.
// No dependencies.
`default_nettype none

package l16ada_pkg;

    localparam int LANES          = 32;
    localparam int HALF_LANES     = 16;
    localparam int LANE_W         = 5;
    localparam int BYTE_LANE_W    = 4;
    localparam int ACC_W          = 18;
    localparam int TBL_W          = 8;
    localparam int BLK_W          = 10;
    localparam int NIB_W          = 4;
    localparam int WRAP_W         = 16;
    localparam int BIAS_SHIFT     = 7;
    localparam int MAX_BLOCKS_DEF = 1024;

    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 11;
    localparam int BLK_CNT_W      = 11;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESULT_MODE = 1'd1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_CODE = 1'b1;

    localparam logic MODE_EXACT  = 1'b0;
    localparam logic MODE_WRAP16 = 1'b1;

endpackage

`default_nettype wire

### sv/l16ada_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read data holds while read enable is low; a read sees the old word on a collision.
// No dependencies.
`default_nettype none

module l16ada_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/lut16_asymmetric_distance_accumulator.sv
// Top level of the 4-bit PQ table distance accumulator.
// Depends on l16ada_pkg and l16ada_ram (two table copies, two accumulator banks).
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------------
//  input    | i_valid / o_ready      | i_kind i_block_index i_code i_entry_value
//           |                        | i_code_byte i_byte_lane
//  result   | o_valid / i_ready      | o_distance o_datapoint_lane o_last
//  config   | i_cfg_we (no wait)     | i_cfg_idx i_cfg_data
//
// Table loads and code bytes are taken one item per cycle, back to back, while
// o_ready is high. A code byte reads both table copies at its accept edge, and
// in the following cycle adds the two bytes into the low and high accumulator
// banks (read-modify-write with a one-deep write-back forward). The code byte
// that closes a group drops o_ready until its drain is done: the closing
// write-back, 32 drain reads of the accumulator banks (one per cycle at best,
// paced by result acceptance), the move of the last entry into the result
// register, and the release of the input. Reset is synchronous: it clears
// control state and the per-entry accumulator valid bits; the table store is
// undefined until loaded and gets no clearing pass.
`default_nettype none

module lut16_asymmetric_distance_accumulator
    import l16ada_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // configuration
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    // input items
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic                    i_kind,
    input  wire logic [BLK_W-1:0]        i_block_index,
    input  wire logic [NIB_W-1:0]        i_code,
    input  wire logic [TBL_W-1:0]        i_entry_value,
    input  wire logic [TBL_W-1:0]        i_code_byte,
    input  wire logic [BYTE_LANE_W-1:0]  i_byte_lane,
    // result items
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic signed [ACC_W-1:0]      o_distance,
    output logic      [LANE_W-1:0]       o_datapoint_lane,
    output logic                         o_last
);

    localparam int TBL_DEPTH = MAX_BLOCKS * HALF_LANES;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int CNT_W     = LANE_W + 1;
    localparam logic [BYTE_LANE_W-1:0] LAST_BYTE_LANE = BYTE_LANE_W'(HALF_LANES - 1);
    localparam logic [LANE_W-1:0]      LAST_LANE      = LANE_W'(LANES - 1);

    // Config registers
    logic [BLK_CNT_W-1:0]    r_block_count;
    logic                    r_result_mode;

    // Code-byte stage after the RAM reads
    logic                    r_s1_vld;
    logic [BYTE_LANE_W-1:0]  r_s1_lane;

    // Last write-back, forwarded to the item right behind
    logic                    r_wb_vld;
    logic [BYTE_LANE_W-1:0]  r_wb_lane;
    logic [ACC_W-1:0]        r_wb_lo;
    logic [ACC_W-1:0]        r_wb_hi;

    // Accumulator entries not valid read as zero
    logic [LANES-1:0]        r_acc_vld;

    // Drain of the accumulators at the end of a group
    logic                    r_drain;
    logic [CNT_W-1:0]        r_issue_cnt;
    logic                    r_pend;
    logic [LANE_W-1:0]       r_pend_idx;
    logic                    r_pend_zero;

    // Result register
    logic                    r_out_vld;
    logic [ACC_W-1:0]        r_out_dist;
    logic [LANE_W-1:0]       r_out_lane;
    logic                    r_out_last;

    logic                    in_go;
    logic                    in_range;
    logic                    load_go;
    logic                    data_go;
    logic                    final_go;
    logic [TBL_AW-1:0]       tbl_waddr;
    logic [TBL_AW-1:0]       tbl_raddr_lo;
    logic [TBL_AW-1:0]       tbl_raddr_hi;
    logic [TBL_W-1:0]        tbl_rd_lo;
    logic [TBL_W-1:0]        tbl_rd_hi;
    logic [ACC_W-1:0]        acc_rd_lo;
    logic [ACC_W-1:0]        acc_rd_hi;
    logic                    acc_re;
    logic [BYTE_LANE_W-1:0]  acc_raddr;
    logic [ACC_W-1:0]        base_lo;
    logic [ACC_W-1:0]        base_hi;
    logic [ACC_W-1:0]        n_sum_lo;
    logic [ACC_W-1:0]        n_sum_hi;
    logic                    issue_go;
    logic                    out_load;
    logic [ACC_W-1:0]        drain_sum;
    logic [ACC_W-1:0]        bias;
    logic [ACC_W-1:0]        diff;
    logic [ACC_W-1:0]        n_out_dist;

    // ---------------------------------------------------------------------
    // Input decode
    // ---------------------------------------------------------------------
    assign o_ready  = !r_drain;
    assign in_go    = i_valid && o_ready;
    // Blocks beyond the store are taken and dropped
    assign in_range = (32'(i_block_index) < 32'(MAX_BLOCKS));
    assign load_go  = in_go && in_range && (i_kind == KIND_LOAD);
    assign data_go  = in_go && in_range && (i_kind == KIND_CODE);
    // Group closes on lane 15 of the last block; a block count of 0 never closes
    assign final_go = data_go && (i_byte_lane == LAST_BYTE_LANE)
                   && ({1'b0, i_block_index} == (r_block_count - BLK_CNT_W'(1)));

    assign tbl_waddr    = TBL_AW'({i_block_index, i_code});
    assign tbl_raddr_lo = TBL_AW'({i_block_index, i_code_byte[NIB_W-1:0]});
    assign tbl_raddr_hi = TBL_AW'({i_block_index, i_code_byte[TBL_W-1:NIB_W]});

    // Two table copies so both nibbles look up in one cycle
    l16ada_ram #(
        .WIDTH (TBL_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_lo (
        .i_clk   (i_clk),
        .i_we    (load_go),
        .i_waddr (tbl_waddr),
        .i_wdata (i_entry_value),
        .i_re    (data_go),
        .i_raddr (tbl_raddr_lo),
        .o_rdata (tbl_rd_lo)
    );

    l16ada_ram #(
        .WIDTH (TBL_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_hi (
        .i_clk   (i_clk),
        .i_we    (load_go),
        .i_waddr (tbl_waddr),
        .i_wdata (i_entry_value),
        .i_re    (data_go),
        .i_raddr (tbl_raddr_hi),
        .o_rdata (tbl_rd_hi)
    );

    // ---------------------------------------------------------------------
    // Accumulator banks: low bank holds datapoints 0..15, high bank 16..31
    // ---------------------------------------------------------------------
    assign acc_re    = data_go || issue_go;
    assign acc_raddr = r_drain ? r_issue_cnt[BYTE_LANE_W-1:0] : i_byte_lane;

    l16ada_ram #(
        .WIDTH (ACC_W),
        .DEPTH (HALF_LANES)
    ) u_acc_lo (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_lane),
        .i_wdata (n_sum_lo),
        .i_re    (acc_re),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rd_lo)
    );

    l16ada_ram #(
        .WIDTH (ACC_W),
        .DEPTH (HALF_LANES)
    ) u_acc_hi (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_lane),
        .i_wdata (n_sum_hi),
        .i_re    (acc_re),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rd_hi)
    );

    // Forward the write that landed at the same edge as this item's read
    always_comb begin
        if (r_wb_vld && (r_wb_lane == r_s1_lane)) begin
            base_lo = r_wb_lo;
            base_hi = r_wb_hi;
        end else begin
            base_lo = r_acc_vld[{1'b0, r_s1_lane}] ? acc_rd_lo : '0;
            base_hi = r_acc_vld[{1'b1, r_s1_lane}] ? acc_rd_hi : '0;
        end
        n_sum_lo = base_lo + ACC_W'(tbl_rd_lo);
        n_sum_hi = base_hi + ACC_W'(tbl_rd_hi);
    end

    // ---------------------------------------------------------------------
    // Drain: issue a read once the closing write is done and the RAM output
    // register is free to take the next entry
    // ---------------------------------------------------------------------
    assign out_load = r_pend && (!r_out_vld || i_ready);
    assign issue_go = r_drain && !r_s1_vld && (r_issue_cnt != CNT_W'(LANES))
                   && (!r_pend || out_load);

    assign drain_sum = r_pend_zero ? '0
                     : (r_pend_idx[LANE_W-1] ? acc_rd_hi : acc_rd_lo);
    assign bias      = ACC_W'({r_block_count, {BIAS_SHIFT{1'b0}}});
    assign diff      = drain_sum - bias;

    always_comb begin
        case (r_result_mode)
            MODE_WRAP16: n_out_dist = {{(ACC_W-WRAP_W){diff[WRAP_W-1]}}, diff[WRAP_W-1:0]};
            default:     n_out_dist = diff;
        endcase
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= BLK_CNT_W'(1);
            r_result_mode <= MODE_EXACT;
            r_s1_vld      <= 1'b0;
            r_wb_vld      <= 1'b0;
            r_acc_vld     <= '0;
            r_drain       <= 1'b0;
            r_issue_cnt   <= '0;
            r_pend        <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_BLOCK_COUNT: r_block_count <= i_cfg_data[BLK_CNT_W-1:0];
                    REG_RESULT_MODE: r_result_mode <= i_cfg_data[0];
                endcase
            end

            // Advance the code byte into the add stage
            r_s1_vld  <= data_go;
            r_s1_lane <= i_byte_lane;

            // Record the write-back for forwarding
            r_wb_vld  <= r_s1_vld;
            r_wb_lane <= r_s1_lane;
            r_wb_lo   <= n_sum_lo;
            r_wb_hi   <= n_sum_hi;

            if (r_s1_vld) begin
                r_acc_vld[{1'b0, r_s1_lane}] <= 1'b1;
                r_acc_vld[{1'b1, r_s1_lane}] <= 1'b1;
            end

            if (final_go) begin
                r_drain     <= 1'b1;
                r_issue_cnt <= '0;
            end else if (r_drain && (r_issue_cnt == CNT_W'(LANES)) && !r_pend) begin
                r_drain <= 1'b0;
            end

            // Read an entry out and clear it in the same step
            if (issue_go) begin
                r_issue_cnt                       <= r_issue_cnt + CNT_W'(1);
                r_acc_vld[r_issue_cnt[LANE_W-1:0]] <= 1'b0;
                r_pend                            <= 1'b1;
                r_pend_idx                        <= r_issue_cnt[LANE_W-1:0];
                r_pend_zero                       <= !r_acc_vld[r_issue_cnt[LANE_W-1:0]];
            end else if (out_load) begin
                r_pend <= 1'b0;
            end

            // Result register: load from the drain, drop when taken
            if (out_load) begin
                r_out_vld  <= 1'b1;
                r_out_dist <= n_out_dist;
                r_out_lane <= r_pend_idx;
                r_out_last <= (r_pend_idx == LAST_LANE);
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_vld;
    assign o_distance       = r_out_dist;
    assign o_datapoint_lane = r_out_lane;
    assign o_last           = r_out_last;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // A result short of the group's last one means the drain is still running
    a_drain_covers_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_last) |-> r_drain)
        else $error("result pending outside of a drain");

    // Drained data waits in the RAM output only while inputs are held off
    a_pend_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !o_ready)
        else $error("accumulator read pending while inputs are taken");

    // A drain starts only after the closing code byte
    a_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_drain) |-> $past(final_go))
        else $error("drain started without a closing item");

    // No drain read may overlap the closing write-back
    a_no_read_over_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue_go |-> !r_wb_vld || !$past(final_go))
        else $error("drain read issued before the closing write landed");

endmodule

`default_nettype wire

### sim/lut16_asymmetric_distance_accumulator_test.sv
// Self-checking bench for the 4-bit PQ table distance accumulator.
// Predicts the 32 lane distances of every group and checks them in order.
// Depends on l16ada_pkg and lut16_asymmetric_distance_accumulator.
`default_nettype none

module lut16_asymmetric_distance_accumulator_test;
    import l16ada_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 300;  // receiver hold-off, long enough to stall the input
    localparam int SETTLE       = 8;    // pipeline drain after the last item of a phase
    localparam int RANDOM_ITEMS = 160;

    // One input item, as it sits on the payload ports.
    typedef struct packed {
        logic                   kind;
        logic [BLK_W-1:0]       blk;
        logic [NIB_W-1:0]       code;
        logic [TBL_W-1:0]       entry;
        logic [TBL_W-1:0]       cbyte;
        logic [BYTE_LANE_W-1:0] lane;
    } t_pq_item;

    // One distance the block should emit.
    typedef struct {
        logic signed [ACC_W-1:0] distance;
        logic [LANE_W-1:0]       lane;
        logic                    last;
    } t_lane_distance;

    logic                   i_clk;
    logic                   i_rst_n    = 1'b0;
    logic                   i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_valid    = 1'b0;
    logic                   o_ready;
    logic                   i_kind;
    logic [BLK_W-1:0]       i_block_index;
    logic [NIB_W-1:0]       i_code;
    logic [TBL_W-1:0]       i_entry_value;
    logic [TBL_W-1:0]       i_code_byte;
    logic [BYTE_LANE_W-1:0] i_byte_lane;
    logic                   o_valid;
    logic                   i_ready    = 1'b0;
    logic signed [ACC_W-1:0] o_distance;
    logic [LANE_W-1:0]      o_datapoint_lane;
    logic                   o_last;

    // Payload register: every field is a port of its own.
    t_pq_item cur_item = '0;
    assign i_kind        = cur_item.kind;
    assign i_block_index = cur_item.blk;
    assign i_code        = cur_item.code;
    assign i_entry_value = cur_item.entry;
    assign i_code_byte   = cur_item.cbyte;
    assign i_byte_lane   = cur_item.lane;

    lut16_asymmetric_distance_accumulator u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_kind           (i_kind),
        .i_block_index    (i_block_index),
        .i_code           (i_code),
        .i_entry_value    (i_entry_value),
        .i_code_byte      (i_code_byte),
        .i_byte_lane      (i_byte_lane),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_distance       (o_distance),
        .o_datapoint_lane (o_datapoint_lane),
        .o_last           (o_last)
    );

    // ------------------------------------------------------------------
    // Predictor state: table mirror, lane sums and register copies.
    // ------------------------------------------------------------------
    logic [TBL_W-1:0]        lut_mirror [0:16383];
    logic [ACC_W-1:0]        lane_acc   [LANES];
    logic [BLK_CNT_W-1:0]    blocks_cfg = 11'd1;
    logic                    mode_cfg   = MODE_EXACT;
    t_lane_distance          distance_q [$];

    // Stimulus-side bookkeeping: which table entries hold a known value.
    t_pq_item item_q [$];
    bit       tbl_written [0:16383];
    int       block_fill  [0:1023];
    int       items_queued = 0;

    int fail_count  = 0;
    int cycle_count = 0;
    bit gaps_on     = 1'b1;   // random idling on both sides
    bit hold_armed  = 1'b0;   // let the receiver hold off once on the next group

    // Apply one accepted item to the predictor; a group close pushes 32 distances.
    task automatic predict_distances(input t_pq_item it);
        logic [BLK_CNT_W-1:0]    close_blk;
        logic [ACC_W-1:0]        bias;
        logic [ACC_W-1:0]        d;
        t_lane_distance          r;
        if (it.kind == KIND_LOAD) begin
            lut_mirror[{it.blk, it.code}] = it.entry;
            return;
        end
        lane_acc[{1'b0, it.lane}] = lane_acc[{1'b0, it.lane}]
                                    + ACC_W'(lut_mirror[{it.blk, it.cbyte[3:0]}]);
        lane_acc[{1'b1, it.lane}] = lane_acc[{1'b1, it.lane}]
                                    + ACC_W'(lut_mirror[{it.blk, it.cbyte[7:4]}]);
        // Close only on lane 15 of the last block; block counts of 0 or above
        // 1024 can never match a 10-bit block index.
        close_blk = blocks_cfg - 1'b1;
        if (it.lane != 4'd15 || {1'b0, it.blk} != close_blk)
            return;
        bias = {blocks_cfg, 7'b0};
        for (int k = 0; k < LANES; k++) begin
            d = lane_acc[k] - bias;
            if (mode_cfg == MODE_WRAP16)
                d = {{(ACC_W-WRAP_W){d[WRAP_W-1]}}, d[WRAP_W-1:0]};
            r.distance = d;
            r.lane     = LANE_W'(k);
            r.last     = (k == LANES - 1);
            distance_q.push_back(r);
            lane_acc[k] = '0;
        end
    endtask

    task automatic push_item(input logic kind, input logic [BLK_W-1:0] blk,
                             input logic [NIB_W-1:0] code, input logic [TBL_W-1:0] entry,
                             input logic [TBL_W-1:0] cbyte,
                             input logic [BYTE_LANE_W-1:0] lane);
        t_pq_item it;
        it = '{kind: kind, blk: blk, code: code, entry: entry, cbyte: cbyte, lane: lane};
        item_q.push_back(it);
        items_queued++;
    endtask

    task automatic queue_load(input logic [BLK_W-1:0] blk, input logic [NIB_W-1:0] code,
                              input logic [TBL_W-1:0] entry);
        if (!tbl_written[{blk, code}]) begin
            tbl_written[{blk, code}] = 1'b1;
            block_fill[blk]++;
        end
        // code byte and lane are don't-care on a load; toggle them anyway
        push_item(KIND_LOAD, blk, code, entry, TBL_W'($urandom), BYTE_LANE_W'($urandom));
    endtask

    task automatic queue_code(input logic [BLK_W-1:0] blk,
                              input logic [BYTE_LANE_W-1:0] lane,
                              input logic [TBL_W-1:0] cbyte);
        push_item(KIND_CODE, blk, NIB_W'($urandom), TBL_W'($urandom), cbyte, lane);
    endtask

    // Code byte with random nibbles, restricted to entries already loaded.
    task automatic queue_rand_code(input int blk, input int lane);
        logic [NIB_W-1:0] lo;
        logic [NIB_W-1:0] hi;
        if (block_fill[blk] == 0)
            queue_load(BLK_W'(blk), NIB_W'($urandom), TBL_W'($urandom));
        do lo = NIB_W'($urandom); while (!tbl_written[{BLK_W'(blk), lo}]);
        do hi = NIB_W'($urandom); while (!tbl_written[{BLK_W'(blk), hi}]);
        queue_code(BLK_W'(blk), BYTE_LANE_W'(lane), {hi, lo});
    endtask

    // Stray item: a table load, a code byte anywhere, or now and then an early close.
    task automatic queue_noise(input int close_blk);
        int blk;
        int lane;
        blk  = (close_blk >= 0 && $urandom_range(0, 1) == 1) ? $urandom_range(0, close_blk)
                                                            : $urandom_range(0, 1023);
        lane = $urandom_range(0, 15);
        case ($urandom_range(0, 3))
            0, 1: queue_load(BLK_W'(blk), NIB_W'($urandom), TBL_W'($urandom));
            default: begin
                if (close_blk >= 0 && $urandom_range(0, 15) == 0) begin
                    queue_rand_code(close_blk, 15);
                end else begin
                    if (blk == close_blk && lane == 15)
                        lane = 14;
                    queue_rand_code(blk, lane);
                end
            end
        endcase
    endtask

    // Well-formed group: lanes in random order with noise mixed in, close last.
    // Small block counts get every byte; large ones only a sample.
    task automatic queue_group(input int nb);
        int pairs [$];
        int blk;
        int lane;
        if (nb <= 3) begin
            for (blk = 0; blk < nb; blk++)
                for (lane = 0; lane < 16; lane++)
                    if (!(blk == nb - 1 && lane == 15))
                        pairs.insert($urandom_range(0, pairs.size()), blk * 16 + lane);
        end else begin
            repeat (8) begin
                blk  = $urandom_range(0, nb - 1);
                lane = $urandom_range(0, 15);
                if (blk == nb - 1 && lane == 15)
                    lane = 14;
                pairs.push_back(blk * 16 + lane);
            end
        end
        foreach (pairs[i]) begin
            if ($urandom_range(0, 5) == 0)
                queue_noise(nb - 1);
            queue_rand_code(pairs[i] / 16, pairs[i] % 16);
        end
        queue_rand_code(nb - 1, 15);
    endtask

    // Register write: one cycle of write enable, mirror updated alongside.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_BLOCK_COUNT)
            blocks_cfg = data;
        else
            mode_cfg = data[0];
    endtask

    task automatic write_mode(input logic mode);
        // upper data bits are ignored by the register; toggle them anyway
        write_reg(REG_RESULT_MODE, {(CFG_DATA_W-1)'($urandom), mode});
    endtask

    // Hold until every item is taken and every distance has come back.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (item_q.size() != 0 || i_valid || distance_q.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and cycle limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: pop pending items, hold each until accepted, predict on accept.
    // ------------------------------------------------------------------
    int send_gap = 0;

    always @(posedge i_clk) begin : drive_items
        t_pq_item nxt;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && o_ready)
                predict_distances(cur_item);
            // advance only when the slot is empty or the current item goes this edge
            if (!i_valid || o_ready) begin
                if (send_gap != 0) begin
                    i_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (item_q.size() != 0) begin
                    nxt = item_q.pop_front();
                    cur_item <= nxt;
                    i_valid  <= 1'b1;
                    if (gaps_on && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 5);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: pace i_ready and check every accepted distance in order.
    // ------------------------------------------------------------------
    int  recv_gap  = 0;
    int  hold_left = 0;
    bit  hold_used = 1'b0;

    always @(posedge i_clk) begin : check_results
        t_lane_distance want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (distance_q.size() == 0) begin
                    $error("unexpected distance item: lane %0d value %0d",
                           o_datapoint_lane, o_distance);
                    fail_count++;
                end else begin
                    want = distance_q.pop_front();
                    if (o_distance !== want.distance) begin
                        $error("distance: expected %0d, got %0d", want.distance, o_distance);
                        fail_count++;
                    end
                    if (o_datapoint_lane !== want.lane) begin
                        $error("datapoint_lane: expected %0d, got %0d",
                               want.lane, o_datapoint_lane);
                        fail_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, o_last);
                        fail_count++;
                    end
                end
            end
            // one long hold-off on the first result of the armed phase, then bursts
            if (hold_left != 0) begin
                i_ready   <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (hold_armed && !hold_used && o_valid) begin
                i_ready   <= 1'b0;
                hold_used <= 1'b1;
                hold_left <= LONG_HOLD;
            end else if (recv_gap != 0) begin
                i_ready  <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                i_ready <= 1'b1;
                if (gaps_on && $urandom_range(0, 7) == 0)
                    recv_gap <= $urandom_range(1, 5);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed phases, random phases, clean tail.
    // ------------------------------------------------------------------
    initial begin
        int  nb;
        int  random_start;
        int  groups;
        bit  emits;
        bit  hold_planned;
        foreach (lane_acc[k])
            lane_acc[k] = '0;
        hold_planned = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings (one block, exact sums): extreme table bytes, the
        // last block, a code byte of the last block that must not close.
        queue_load(10'd0, 4'd0, 8'h00);
        queue_load(10'd0, 4'd15, 8'hFF);
        queue_load(10'd0, 4'd7, 8'h80);
        queue_load(10'd1023, 4'd5, 8'h80);
        queue_load(10'd1023, 4'd10, 8'h7F);
        queue_code(10'd0, 4'd0, 8'hF0);
        queue_code(10'd0, 4'd7, 8'h7F);
        queue_code(10'd1023, 4'd15, 8'hA5);
        queue_code(10'd0, 4'd15, 8'h0F);
        wait_drained();

        // Largest block count: the bias reaches 2^17, seen wrapped and exact.
        write_reg(REG_BLOCK_COUNT, 11'd1024);
        write_mode(MODE_WRAP16);
        @(negedge i_clk);
        queue_code(10'd1023, 4'd3, 8'h5A);
        queue_code(10'd1023, 4'd15, 8'hAA);
        wait_drained();
        write_mode(MODE_EXACT);
        @(negedge i_clk);
        queue_code(10'd1023, 4'd15, 8'h55);
        wait_drained();

        // Zero and oversized block counts never close; sums carry over.
        write_reg(REG_BLOCK_COUNT, 11'd0);
        @(negedge i_clk);
        queue_code(10'd0, 4'd15, 8'hFF);
        queue_code(10'd1023, 4'd15, 8'h55);
        wait_drained();
        write_reg(REG_BLOCK_COUNT, 11'd2047);
        write_mode(MODE_WRAP16);
        @(negedge i_clk);
        queue_code(10'd1023, 4'd15, 8'hA5);
        queue_code(10'd0, 4'd15, 8'h07);
        wait_drained();
        write_reg(REG_BLOCK_COUNT, 11'd1);
        write_mode(MODE_EXACT);
        @(negedge i_clk);
        queue_code(10'd0, 4'd15, 8'h00);
        wait_drained();

        // Random phases: mostly well-formed groups, some phases that never close.
        random_start = items_queued;
        while (items_queued - random_start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                5:       nb = 257;                      // bias just past int16
                6:       nb = $urandom_range(4, 1024);
                7:       nb = 1024;
                8:       nb = $urandom_range(0, 1) ? 0 : 2047;
                default: nb = $urandom_range(1, 3);
            endcase
            // the first random phase always carries the long receiver hold-off
            if (!hold_planned)
                nb = $urandom_range(1, 3);
            emits = (nb >= 1 && nb <= 1024);
            write_reg(REG_BLOCK_COUNT, BLK_CNT_W'(nb));
            if ($urandom_range(0, 3) != 0)
                write_mode(1'($urandom));
            @(negedge i_clk);
            gaps_on = ($urandom_range(0, 3) != 0);
            groups  = $urandom_range(1, 2);
            if (emits && nb <= 3 && !hold_planned) begin
                // receiver stalls on the first group while two more wait behind it
                hold_planned = 1'b1;
                hold_armed   = 1'b1;
                groups       = 3;
            end
            if (emits) begin
                repeat (groups)
                    queue_group(nb);
            end else begin
                repeat (12)
                    queue_noise(-1);
            end
            wait_drained();
        end

        // Tail: no idling on either side.
        gaps_on = 1'b0;
        write_reg(REG_BLOCK_COUNT, 11'd2);
        write_mode(1'($urandom));
        @(negedge i_clk);
        repeat (2)
            queue_group(2);
        wait_drained();
        repeat (40) @(negedge i_clk);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
sv/l16ada_pkg.sv
sv/l16ada_ram.sv
sv/lut16_asymmetric_distance_accumulator.sv
sim/lut16_asymmetric_distance_accumulator_test.sv
